// ===== src/plnu_pkg.sv =====
// Package for the pose blend unit: widths, stage positions, operation codes
// and the transaction payload types. No dependencies.
`default_nettype none

package plnu_pkg;

    // Component format
    localparam int COMP_W   = 32;
    localparam int FRAC     = 16;
    localparam int T_W      = FRAC + 1;
    localparam int LANES    = 4;
    localparam int PROD_W   = 2 * COMP_W;

    // Lerp datapath
    localparam int D_W      = COMP_W + 2;
    localparam int P_W      = D_W + T_W + 1;
    localparam int MAG_W    = COMP_W;
    localparam int MSB_W    = $clog2(MAG_W);

    // Normalization: largest magnitude lands in [2^NORM_MSB, 2^(NORM_MSB+1))
    localparam int NORM_MSB = 29;
    localparam int SCL_W    = NORM_MSB + 1;
    localparam int SQR_W    = 2 * SCL_W;
    localparam int SUMSQ_W  = SQR_W + 2;
    localparam int ROOT_W   = SUMSQ_W / 2;
    localparam int Q_W      = FRAC + 1;
    localparam int NUM_W    = SCL_W + FRAC + 1;
    localparam int DIV_STG  = Q_W + 1;

    // Pipeline stage positions
    localparam int ST_SCALE = 11;
    localparam int ST_SUMSQ = 13;
    localparam int ST_ROOT  = ST_SUMSQ + ROOT_W;
    localparam int ST_LAST  = ST_ROOT + DIV_STG;

    typedef enum logic [0:0] {
        KIND_LERP  = 1'b0,
        KIND_NLERP = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic signed [COMP_W-1:0] a_w;
        logic signed [COMP_W-1:0] a_x;
        logic signed [COMP_W-1:0] a_y;
        logic signed [COMP_W-1:0] a_z;
        logic signed [COMP_W-1:0] b_w;
        logic signed [COMP_W-1:0] b_x;
        logic signed [COMP_W-1:0] b_y;
        logic signed [COMP_W-1:0] b_z;
        logic [T_W-1:0]           blend;
    } t_in_item;

    typedef struct packed {
        logic signed [COMP_W-1:0] r_w;
        logic signed [COMP_W-1:0] r_x;
        logic signed [COMP_W-1:0] r_y;
        logic signed [COMP_W-1:0] r_z;
        logic                     zero_norm;
    } t_out_item;

    // Side data that rides along the normalize, root and divide stages
    typedef struct packed {
        t_kind                         kind;
        logic                          zero;
        logic [LANES-1:0]              sgn;
        logic [LANES-1:0][COMP_W-1:0]  lin;
        logic [LANES-1:0][SCL_W-1:0]   mag;
    } t_carry;

endpackage

`default_nettype wire

// ===== src/plnu_lerp_lane.sv =====
// One component lane: optional negation of b, blend, rounding and
// saturation; four pipeline stages. Depends on plnu_pkg.
`default_nettype none

module plnu_lerp_lane import plnu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [COMP_W-1:0] i_a,
    input  logic signed [COMP_W-1:0] i_b,
    input  logic [T_W-1:0]           i_t,
    input  logic                     i_flip,
    output logic signed [COMP_W-1:0] o_lin,
    output logic [MAG_W-1:0]         o_mag,
    output logic                     o_neg
);

    localparam logic signed [P_W-1:0] HALF = P_W'(1) << (FRAC - 1);
    localparam logic signed [COMP_W-1:0] SAT_MAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam logic signed [COMP_W-1:0] SAT_MIN = {1'b1, {(COMP_W-1){1'b0}}};

    logic signed [D_W-1:0]    w_ax;
    logic signed [D_W-1:0]    w_bx;
    logic signed [D_W-1:0]    w_bsel;
    logic signed [D_W-1:0]    n_d;
    logic signed [D_W-1:0]    r_d;
    logic signed [COMP_W-1:0] r_a1;
    logic signed [COMP_W-1:0] r_a2;
    logic [T_W-1:0]           r_t1;
    logic signed [P_W-1:0]    n_dt;
    logic signed [P_W-1:0]    r_dt;
    logic signed [P_W-1:0]    w_rnd;
    logic signed [P_W-1:0]    w_sh;
    logic signed [D_W-1:0]    n_v;
    logic signed [D_W-1:0]    r_v;
    logic [D_W-1:0]           w_abs;
    logic signed [COMP_W-1:0] n_lin;

    // Difference against the possibly negated end operand
    always_comb begin
        w_ax   = D_W'(i_a);
        w_bx   = D_W'(i_b);
        w_bsel = i_flip ? -w_bx : w_bx;
        n_d    = w_bsel - w_ax;
    end

    // Scale the difference by t
    assign n_dt = r_d * $signed({1'b0, r_t1});

    // Round half up, drop fraction, add start operand
    always_comb begin
        w_rnd = r_dt + HALF;
        w_sh  = w_rnd >>> FRAC;
        n_v   = D_W'(r_a2) + $signed(w_sh[D_W-1:0]);
    end

    // Saturate and split into magnitude and sign
    always_comb begin
        if ((&r_v[D_W-1:COMP_W-1]) || !(|r_v[D_W-1:COMP_W-1])) begin
            n_lin = r_v[COMP_W-1:0];
        end else begin
            n_lin = r_v[D_W-1] ? SAT_MIN : SAT_MAX;
        end
        w_abs = r_v[D_W-1] ? -r_v : r_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d   <= n_d;
            r_a1  <= i_a;
            r_t1  <= i_t;
            r_dt  <= n_dt;
            r_a2  <= r_a1;
            r_v   <= n_v;
            o_lin <= n_lin;
            o_mag <= w_abs[MAG_W-1:0];
            o_neg <= r_v[D_W-1];
        end
    end

endmodule

`default_nettype wire

// ===== src/plnu_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, ROOT_W stages.
// Depends on plnu_pkg.
`default_nettype none

module plnu_sqrt import plnu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [SUMSQ_W-1:0] i_x,
    output logic [ROOT_W-1:0]  o_root
);

    logic [SUMSQ_W-1:0] r_rem  [ROOT_W];
    logic [ROOT_W-1:0]  r_root [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stg
        localparam int K = ROOT_W - 1 - s;
        logic [SUMSQ_W-1:0] w_rem_in;
        logic [ROOT_W-1:0]  w_root_in;
        logic [63:0]        w_trial;
        logic               w_take;

        if (s == 0) begin : g_first
            assign w_rem_in  = i_x;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
        end

        // Try setting bit K: cost is root*2^(K+1) + 2^(2K)
        always_comb begin
            w_trial = (64'(w_root_in) << (K + 1)) | (64'd1 << (2 * K));
            w_take  = 64'(w_rem_in) >= w_trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_take ? (w_rem_in - w_trial[SUMSQ_W-1:0]) : w_rem_in;
                r_root[s] <= w_take ? (w_root_in | (ROOT_W'(1) << K)) : w_root_in;
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

`default_nettype wire

// ===== src/plnu_div_lane.sv =====
// One divide lane: rounded mag * 2^FRAC / root, restoring division with
// one quotient bit per stage after a numerator stage. Depends on plnu_pkg.
`default_nettype none

module plnu_div_lane import plnu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SCL_W-1:0]  i_mag,
    input  logic [ROOT_W-1:0] i_root,
    output logic [Q_W-1:0]    o_q
);

    logic [NUM_W-1:0]  r_num;
    logic [ROOT_W-1:0] r_den0;
    logic [NUM_W-1:0]  r_rem [Q_W];
    logic [ROOT_W-1:0] r_den [Q_W];
    logic [Q_W-1:0]    r_q   [Q_W];

    // Form numerator with half the divisor for round-half-up
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= (NUM_W'(i_mag) << FRAC) + NUM_W'(i_root >> 1);
            r_den0 <= i_root;
        end
    end

    for (genvar s = 0; s < Q_W; s++) begin : g_stg
        localparam int J = Q_W - 1 - s;
        logic [NUM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_den_in;
        logic [Q_W-1:0]    w_q_in;
        logic [NUM_W-1:0]  w_trial;
        logic              w_take;

        if (s == 0) begin : g_first
            assign w_rem_in = r_num;
            assign w_den_in = r_den0;
            assign w_q_in   = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_q_in   = r_q[s-1];
        end

        always_comb begin
            w_trial = NUM_W'(w_den_in) << J;
            w_take  = w_rem_in >= w_trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_take ? (w_rem_in - w_trial) : w_rem_in;
                r_den[s] <= w_den_in;
                r_q[s]   <= w_take ? (w_q_in | (Q_W'(1) << J)) : w_q_in;
            end
        end
    end

    assign o_q = r_q[Q_W-1];

endmodule

`default_nettype wire

// ===== src/pose_lerp_nlerp_unit.sv =====
// Top level of the pose blend unit: dot-product sign, four lerp lanes,
// merge/normalize, root, four divide lanes and a two-entry output queue.
// Depends on plnu_pkg, plnu_lerp_lane, plnu_sqrt, plnu_div_lane.
//
//   channel | direction | handshake                    | payload
//   input   | in        | i_in_valid / o_in_ready      | i_in_data  (t_in_item)
//   output  | out       | o_out_valid / i_out_ready    | o_out_data (t_out_item)
//
// One transaction per cycle is accepted while the pipeline advances; there are 62
// pipeline stages ahead of the output queue, among them the 31-stage square root and
// the 18-stage divide lanes. The whole pipeline advances while the output queue
// has a free entry; it freezes when the queue holds two results.
// Reset (synchronous, active low) clears stage valid bits and the queue.
`default_nettype none

module pose_lerp_nlerp_unit import plnu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam logic [T_W-1:0]    T_ONE = T_W'(1) << FRAC;
    localparam logic [COMP_W-1:0] C_ONE = COMP_W'(1) << FRAC;

    logic                     w_en;
    logic [ST_LAST:1]         r_vld;

    // Stages 1..4: operands and dot-product sign
    logic signed [COMP_W-1:0] w_a [LANES];
    logic signed [COMP_W-1:0] w_b [LANES];
    t_kind                    r_s1_kind, r_s2_kind, r_s3_kind, r_s4_kind;
    logic signed [COMP_W-1:0] r_s1_a [LANES];
    logic signed [COMP_W-1:0] r_s1_b [LANES];
    logic signed [COMP_W-1:0] r_s2_a [LANES];
    logic signed [COMP_W-1:0] r_s2_b [LANES];
    logic signed [COMP_W-1:0] r_s3_a [LANES];
    logic signed [COMP_W-1:0] r_s3_b [LANES];
    logic signed [COMP_W-1:0] r_s4_a [LANES];
    logic signed [COMP_W-1:0] r_s4_b [LANES];
    logic [T_W-1:0]           r_s1_t, r_s2_t, r_s3_t, r_s4_t;
    logic signed [PROD_W-1:0] r_s2_prod [LANES];
    logic signed [PROD_W:0]   r_s3_psum [2];
    logic signed [PROD_W+1:0] w_dot;
    logic                     r_s4_flip;

    // Stages 5..8: lanes
    logic [3:0]               r_kind_l;
    logic signed [COMP_W-1:0] w_lin [LANES];
    logic [MAG_W-1:0]         w_mag [LANES];
    logic [LANES-1:0]         w_neg;

    // Stages 9..10: merge
    logic [MAG_W-1:0]         w_max01, w_max23, n_max;
    logic [MAG_W-1:0]         r_s9_max;
    logic [MAG_W-1:0]         r_s9_mag [LANES];
    logic [MAG_W-1:0]         r_s10_mag [LANES];
    t_kind                    r_s9_kind, r_s10_kind;
    logic [LANES-1:0]         r_s9_sgn, r_s10_sgn;
    logic [COMP_W-1:0]        r_s9_lin [LANES];
    logic [COMP_W-1:0]        r_s10_lin [LANES];
    logic [MSB_W-1:0]         n_msb, r_s10_msb;
    logic                     r_s10_zero;

    // Stages 11..: normalize, squares, root, divide
    t_carry                   n_car;
    t_carry                   r_car [ST_SCALE:ST_LAST];
    logic [SQR_W-1:0]         r_s12_sq [LANES];
    logic [SUMSQ_W-1:0]       r_s13_sum;
    logic [ROOT_W-1:0]        w_root;
    logic [Q_W-1:0]           w_q [LANES];

    // Output queue
    t_out_item                n_res;
    t_out_item                r_qd [2];
    logic                     r_wp, r_rp;
    logic [1:0]               r_cnt;
    logic                     w_push, w_pop;

    // Advance while the queue has room
    assign w_en       = (r_cnt != 2'd2);
    assign o_in_ready = w_en;

    assign w_a[0] = i_in_data.a_w;
    assign w_a[1] = i_in_data.a_x;
    assign w_a[2] = i_in_data.a_y;
    assign w_a[3] = i_in_data.a_z;
    assign w_b[0] = i_in_data.b_w;
    assign w_b[1] = i_in_data.b_x;
    assign w_b[2] = i_in_data.b_y;
    assign w_b[3] = i_in_data.b_z;

    assign w_dot = (PROD_W+2)'(r_s3_psum[0]) + (PROD_W+2)'(r_s3_psum[1]);

    // Capture, multiply, pair sums, sign
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_kind <= i_in_data.kind;
            r_s1_t    <= (i_in_data.blend > T_ONE) ? T_ONE : i_in_data.blend;
            r_s2_kind <= r_s1_kind;
            r_s2_t    <= r_s1_t;
            r_s3_kind <= r_s2_kind;
            r_s3_t    <= r_s2_t;
            r_s4_kind <= r_s3_kind;
            r_s4_t    <= r_s3_t;
            for (int i = 0; i < LANES; i++) begin
                r_s1_a[i]    <= w_a[i];
                r_s1_b[i]    <= w_b[i];
                r_s2_a[i]    <= r_s1_a[i];
                r_s2_b[i]    <= r_s1_b[i];
                r_s2_prod[i] <= PROD_W'(r_s1_a[i]) * PROD_W'(r_s1_b[i]);
                r_s3_a[i]    <= r_s2_a[i];
                r_s3_b[i]    <= r_s2_b[i];
                r_s4_a[i]    <= r_s3_a[i];
                r_s4_b[i]    <= r_s3_b[i];
            end
            r_s3_psum[0] <= (PROD_W+1)'(r_s2_prod[0]) + (PROD_W+1)'(r_s2_prod[1]);
            r_s3_psum[1] <= (PROD_W+1)'(r_s2_prod[2]) + (PROD_W+1)'(r_s2_prod[3]);
            r_s4_flip    <= (r_s3_kind == KIND_NLERP) && w_dot[PROD_W+1];
            r_kind_l     <= {r_kind_l[2:0], r_s4_kind};
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        plnu_lerp_lane u_lerp (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_a    (r_s4_a[g]),
            .i_b    (r_s4_b[g]),
            .i_t    (r_s4_t),
            .i_flip (r_s4_flip),
            .o_lin  (w_lin[g]),
            .o_mag  (w_mag[g]),
            .o_neg  (w_neg[g])
        );
    end

    // Largest magnitude and its leading one
    always_comb begin
        w_max01 = (w_mag[0] > w_mag[1]) ? w_mag[0] : w_mag[1];
        w_max23 = (w_mag[2] > w_mag[3]) ? w_mag[2] : w_mag[3];
        n_max   = (w_max01 > w_max23) ? w_max01 : w_max23;
    end

    always_comb begin
        n_msb = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (r_s9_max[i]) begin
                n_msb = MSB_W'(i);
            end
        end
    end

    // Scale all magnitudes by the common power of two
    always_comb begin
        n_car.kind = r_s10_kind;
        n_car.zero = r_s10_zero;
        n_car.sgn  = r_s10_sgn;
        for (int i = 0; i < LANES; i++) begin
            n_car.lin[i] = r_s10_lin[i];
            if (r_s10_msb >= MSB_W'(NORM_MSB)) begin
                n_car.mag[i] = SCL_W'(r_s10_mag[i] >> (r_s10_msb - MSB_W'(NORM_MSB)));
            end else begin
                n_car.mag[i] = SCL_W'(r_s10_mag[i] << (MSB_W'(NORM_MSB) - r_s10_msb));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s9_max   <= n_max;
            r_s9_kind  <= t_kind'(r_kind_l[3]);
            r_s9_sgn   <= w_neg;
            r_s10_kind <= r_s9_kind;
            r_s10_sgn  <= r_s9_sgn;
            r_s10_msb  <= n_msb;
            r_s10_zero <= (r_s9_max == '0);
            for (int i = 0; i < LANES; i++) begin
                r_s9_mag[i]  <= w_mag[i];
                r_s9_lin[i]  <= w_lin[i];
                r_s10_mag[i] <= r_s9_mag[i];
                r_s10_lin[i] <= r_s9_lin[i];
                r_s12_sq[i]  <= SQR_W'(r_car[ST_SCALE].mag[i]) *
                                SQR_W'(r_car[ST_SCALE].mag[i]);
            end
            r_s13_sum <= SUMSQ_W'(r_s12_sq[0]) + SUMSQ_W'(r_s12_sq[1]) +
                         SUMSQ_W'(r_s12_sq[2]) + SUMSQ_W'(r_s12_sq[3]);
            r_car[ST_SCALE] <= n_car;
        end
    end

    // Carry side data along the squares, root and divide stages
    for (genvar k = ST_SCALE + 1; k <= ST_LAST; k++) begin : g_car
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_car[k] <= r_car[k-1];
            end
        end
    end

    plnu_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (r_s13_sum),
        .o_root (w_root)
    );

    for (genvar g = 0; g < LANES; g++) begin : g_div
        plnu_div_lane u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_mag  (r_car[ST_ROOT].mag[g]),
            .i_root (w_root),
            .o_q    (w_q[g])
        );
    end

    // Pick the result for the kind
    always_comb begin
        logic [COMP_W-1:0] v_c [LANES];
        for (int i = 0; i < LANES; i++) begin
            if (r_car[ST_LAST].kind == KIND_LERP) begin
                v_c[i] = r_car[ST_LAST].lin[i];
            end else if (r_car[ST_LAST].zero) begin
                v_c[i] = (i == 0) ? C_ONE : '0;
            end else if (r_car[ST_LAST].sgn[i]) begin
                v_c[i] = -COMP_W'(w_q[i]);
            end else begin
                v_c[i] = COMP_W'(w_q[i]);
            end
        end
        n_res.r_w       = v_c[0];
        n_res.r_x       = v_c[1];
        n_res.r_y       = v_c[2];
        n_res.r_z       = v_c[3];
        n_res.zero_norm = (r_car[ST_LAST].kind == KIND_NLERP) && r_car[ST_LAST].zero;
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[ST_LAST-1:1], i_in_valid};
        end
    end

    // Output queue: push finished transactions, pop on handshake
    assign w_push      = w_en && r_vld[ST_LAST];
    assign w_pop       = (r_cnt != 2'd0) && i_out_ready;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_qd[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_qd[r_wp] <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    // Accepted transaction enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[1])
        else $error("accepted transaction did not enter stage 1");

    // Stalled input means a result is on offer
    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output queue");

    // Normalized root has a one in its top two bits
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_ROOT] && (r_car[ST_ROOT].kind == KIND_NLERP) && !r_car[ST_ROOT].zero)
        |-> (w_root[ROOT_W-1:ROOT_W-2] != 2'b00))
        else $error("square root out of normalized range");

    // Zero-length blend yields the identity
    a_zero_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.zero_norm) |->
        (o_out_data.r_w == C_ONE && o_out_data.r_x == '0 &&
         o_out_data.r_y == '0 && o_out_data.r_z == '0))
        else $error("zero-norm result is not the identity");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for pose_lerp_nlerp_unit: directed table, then random vector lerp
// and quaternion nlerp transactions checked against a local blend predictor.
// Depends on plnu_pkg and the pose_lerp_nlerp_unit RTL.
`timescale 1ns / 100ps

module tb_top;
    import plnu_pkg::*;

    localparam int  N_RANDOM    = 1400;
    localparam int  HOLD_CYCLES = 300;
    localparam int  TAIL_CYCLES = 100;
    localparam int  WDOG_LIMIT  = 3000;
    localparam longint ONE_Q    = 64'sd65536;

    typedef struct {
        t_in_item  stim;
        bit        typed;
        t_out_item res;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    t_out_item pending_results[$];
    t_row      directed_rows[$];
    int        n_mismatch = 0;
    int        n_checked  = 0;
    int        n_lerp     = 0;
    int        n_nlerp    = 0;
    int        n_zero     = 0;
    int        n_clamped  = 0;
    int        idle_cycles = 0;
    bit        hold_request = 1'b0;
    bit        send_calm   = 1'b0;
    bit        recv_calm   = 1'b0;

    pose_lerp_nlerp_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Lerp of one component with round-half-up on the fraction
    function automatic longint lerp_comp(longint a, longint b, longint t);
        longint p;
        p = (b - a) * t + (ONE_Q >>> 1);
        return a + (p >>> FRAC);
    endfunction

    function automatic logic signed [COMP_W-1:0] clamp_comp(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[COMP_W-1:0];
    endfunction

    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    // Expected result of one transaction
    function automatic t_out_item blend_predict(t_in_item it);
        longint av[4], bv[4], cv[4];
        longint unsigned mag[4], m, sq, root, q;
        logic signed [67:0] dot, xa, xb;
        int sr, sl;
        longint t;
        bit neg;
        t_out_item r;
        t = it.blend;
        if (t > ONE_Q) t = ONE_Q;
        av[0] = it.a_w; av[1] = it.a_x; av[2] = it.a_y; av[3] = it.a_z;
        bv[0] = it.b_w; bv[1] = it.b_x; bv[2] = it.b_y; bv[3] = it.b_z;
        r = '0;
        if (it.kind == KIND_LERP) begin
            for (int i = 0; i < 4; i++) cv[i] = lerp_comp(av[i], bv[i], t);
        end else begin
            dot = '0;
            for (int i = 0; i < 4; i++) begin
                xa = av[i];
                xb = bv[i];
                dot += xa * xb;
            end
            neg = dot < 0;
            m = 0;
            for (int i = 0; i < 4; i++) begin
                cv[i] = lerp_comp(av[i], neg ? -bv[i] : bv[i], t);
                mag[i] = cv[i] < 0 ? -cv[i] : cv[i];
                if (mag[i] > m) m = mag[i];
            end
            if (m == 0) begin
                cv[0] = ONE_Q; cv[1] = 0; cv[2] = 0; cv[3] = 0;
                r.zero_norm = 1'b1;
            end else begin
                sr = 0;
                sl = 0;
                while (m >= (64'd1 << 30)) begin m >>= 1; sr++; end
                while (m < (64'd1 << 29)) begin m <<= 1; sl++; end
                sq = 0;
                for (int i = 0; i < 4; i++) begin
                    mag[i] = (mag[i] >> sr) << sl;
                    sq += mag[i] * mag[i];
                end
                root = int_root(sq);
                for (int i = 0; i < 4; i++) begin
                    q = (mag[i] * 64'd65536 + (root >> 1)) / root;
                    cv[i] = cv[i] < 0 ? -longint'(q) : longint'(q);
                end
            end
        end
        r.r_w = clamp_comp(cv[0]);
        r.r_x = clamp_comp(cv[1]);
        r.r_y = clamp_comp(cv[2]);
        r.r_z = clamp_comp(cv[3]);
        return r;
    endfunction

    function automatic t_in_item make_item(t_kind k, int aw, int ax, int ay, int az,
                                           int bw, int bx, int by, int bz, int t);
        t_in_item it;
        it.kind = k;
        it.a_w = aw; it.a_x = ax; it.a_y = ay; it.a_z = az;
        it.b_w = bw; it.b_x = bx; it.b_y = by; it.b_z = bz;
        it.blend = t[T_W-1:0];
        return it;
    endfunction

    function automatic logic signed [COMP_W-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2:       return 0;
            default: return $signed($urandom_range(0, 262143)) - 131072;
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.kind  = t_kind'($urandom_range(0, 1));
        it.a_w = rand_comp(); it.a_x = rand_comp(); it.a_y = rand_comp(); it.a_z = rand_comp();
        it.b_w = rand_comp(); it.b_x = rand_comp(); it.b_y = rand_comp(); it.b_z = rand_comp();
        case ($urandom_range(0, 9))
            0:       it.blend = $urandom_range(65537, 131071);
            1:       it.blend = $urandom_range(0, 1) ? 0 : 65536;
            default: it.blend = $urandom_range(0, 65536);
        endcase
        // zero-length blend: zero start operand taken at blend zero
        if ($urandom_range(0, 19) == 0) begin
            it.kind = KIND_NLERP;
            it.a_w = 0; it.a_x = 0; it.a_y = 0; it.a_z = 0;
            it.blend = 0;
        end
        return it;
    endfunction

    // Offer one transaction after a random gap, then hold until accepted
    task automatic send_item(t_in_item it, bit typed, t_out_item res);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(typed ? res : blend_predict(it));
        if (it.kind == KIND_LERP) n_lerp++; else n_nlerp++;
        if (it.blend > 17'd65536) n_clamped++;
    endtask

    // Compare one result transaction against the oldest expectation
    task automatic check_result(t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending_results.pop_front();
        n_checked++;
        if (got.zero_norm) n_zero++;
        if (got.r_w !== want.r_w || got.r_x !== want.r_x || got.r_y !== want.r_y ||
            got.r_z !== want.r_z || got.zero_norm !== want.zero_norm) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("mismatch: exp w=%h x=%h y=%h z=%h zn=%b got w=%h x=%h y=%h z=%h zn=%b",
                         want.r_w, want.r_x, want.r_y, want.r_z, want.zero_norm,
                         got.r_w, got.r_x, got.r_y, got.r_z, got.zero_norm);
        end
    endtask

    // Receiver: random stall per transaction, one long hold when requested
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = recv_calm ? 0 : $urandom_range(0, 17);
            if (hold_request) begin
                gap = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (gap > 0) begin
                @(negedge i_clk) i_out_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            check_result(o_out_data);
        end
    end

    // Watchdog: count cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_row      row;
        t_out_item ident, unit_w;
        ident  = '{r_w: 32'sd65536, r_x: 0, r_y: 0, r_z: 0, zero_norm: 1'b1};
        unit_w = '{r_w: 32'sd65536, r_x: 0, r_y: 0, r_z: 0, zero_norm: 1'b0};

        // Directed table; typed rows carry their result, the rest use the predictor
        row = '{make_item(KIND_LERP, 32'h7fffffff, 32'h80000000, 1, -1, 5, 6, 7, 8, 0), 1,
                '{32'sh7fffffff, 32'sh80000000, 1, -1, 1'b0}};
        directed_rows.push_back(row);
        row = '{make_item(KIND_LERP, 5, 6, 7, 8, 32'h80000000, 32'h7fffffff, -3, 0, 65536), 1,
                '{32'sh80000000, 32'sh7fffffff, -3, 0, 1'b0}};
        directed_rows.push_back(row);
        row = '{make_item(KIND_LERP, 1, 2, 3, 4, 9, 8, 7, 6, 131071), 1, '{9, 8, 7, 6, 1'b0}};
        directed_rows.push_back(row);
        row = '{make_item(KIND_NLERP, 0, 0, 0, 0, 0, 0, 0, 0, 32768), 1, ident};
        directed_rows.push_back(row);
        row = '{make_item(KIND_NLERP, 65536, 0, 0, 0, 65536, 0, 0, 0, 12345), 1, unit_w};
        directed_rows.push_back(row);
        row = '{make_item(KIND_NLERP, 0, 0, 0, 0, 1, 2, 3, 4, 0), 1, ident};
        directed_rows.push_back(row);
        row.typed = 0;
        row.stim = make_item(KIND_LERP, 32'h80000000, 32'h7fffffff, 0, 0,
                             32'h7fffffff, 32'h80000000, 0, 0, 32768);
        directed_rows.push_back(row);
        row.stim = make_item(KIND_NLERP, 65536, 0, 0, 0, -65536, 1000, 0, 0, 32768);
        directed_rows.push_back(row);
        row.stim = make_item(KIND_NLERP, 65536, 0, 0, 0, 0, 65536, 0, 0, 32768);
        directed_rows.push_back(row);
        row.stim = make_item(KIND_NLERP, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                             32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                             32'h7fffffff, 65536);
        directed_rows.push_back(row);
        row.stim = make_item(KIND_NLERP, 1, -1, 1, -1, 2, 3, -4, 5, 65535);
        directed_rows.push_back(row);
        row.stim = make_item(KIND_NLERP, 46341, 0, 46341, 0, 0, 46341, 0, -46341, 131071);
        directed_rows.push_back(row);
        row.stim = make_item(KIND_LERP, -1, 0, 1, 32'h7fffffff, 1, -1, 0, 32'h80000000, 1);
        directed_rows.push_back(row);
        row.stim = make_item(KIND_NLERP, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                             32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                             32'hffffffff, 65537);
        directed_rows.push_back(row);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].res);

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % 64 == 0) begin
                send_calm = ($urandom_range(0, 3) == 0);
                recv_calm = ($urandom_range(0, 3) == 0);
            end
            // back up the pipeline once with a long receiver hold
            if (k == 400) begin
                send_calm = 1'b1;
                hold_request = 1'b1;
            end
            // drain fully once before continuing
            if (k == 900) begin
                @(negedge i_clk) i_in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            send_item(rand_item(), 1'b0, '0);
        end
        @(negedge i_clk) i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d vector lerp, %0d quaternion nlerp transactions.",
                 n_checked, n_lerp, n_nlerp);
        $display("Zero-length blends: %0d, clamped blend factors: %0d, mismatches: %0d.",
                 n_zero, n_clamped, n_mismatch);
        if (n_mismatch == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== pose_lerp_nlerp_unit.f =====
src/plnu_pkg.sv
src/plnu_lerp_lane.sv
src/plnu_sqrt.sv
src/plnu_div_lane.sv
src/pose_lerp_nlerp_unit.sv
tb/tb_top.sv
